// ===== hw/rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// shared constants, codes and controller/datapath structs of the keyed sum
// aggregation table
// ----------------------------------------------------------------------------
`default_nettype none
package kst_pkg;

	localparam int SLOTS      = 1024;
	localparam int COMPONENTS = 8;

	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int COMP_W    = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
	localparam int SUM_DEPTH = SLOTS * COMPONENTS;
	localparam int SUM_AW    = $clog2(SUM_DEPTH);
	localparam int HASH_LSB  = 4;

	localparam logic REQ_CAPTURE = 1'b0;
	localparam logic REQ_DRAIN   = 1'b1;
	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_STATS  = 1'b1;

	typedef struct packed {
		logic load_item;
		logic cnt_calls;
		logic cnt_invalid;
		logic cnt_overflow;
		logic cnt_full;
		logic calc_delta;
		logic probe_init;
		logic probe_rd;
		logic probe_next;
		logic claim;
		logic zero_wr;
		logic add_rd;
		logic add_posted;
		logic add_delta;
		logic dr_list_rd;
		logic dr_slot_rd;
		logic dr_sum_rd;
		logic emit_entry;
		logic emit_stats;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic enabled;
		logic is_drain;
		logic invalid;
		logic delta_ovf;
		logic slot_valid;
		logic key_match;
		logic slots_exhausted;
		logic tries_last;
		logic zc_last;
		logic posted_ovf;
		logic delta_add_ovf;
		logic drain_more;
		logic out_busy;
		logic clr_last;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kst_ifs.sv =====
// ----------------------------------------------------------------------------
// kst channel interfaces
// valid/ready channels for request items, result items and the config write
// ----------------------------------------------------------------------------
`default_nettype none
interface kst_item_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [31:0]        key;
	logic signed [7:0]  component;
	logic signed [63:0] amount;
	logic signed [63:0] before_value;
	logic signed [63:0] after_value;

	modport source (output valid, req_type, key, component, amount, before_value,
		after_value, input ready);
	modport sink (input valid, req_type, key, component, amount, before_value,
		after_value, output ready);
endinterface

interface kst_result_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [31:0]        entry_key;
	logic [4:0]         entry_component;
	logic signed [63:0] posted_sum;
	logic signed [63:0] delta_sum;
	logic [31:0]        calls;
	logic [31:0]        clamped_calls;
	logic [31:0]        invalid_count;
	logic [31:0]        overflow_count;
	logic [31:0]        full_count;
	logic               last;

	modport source (output valid, kind, entry_key, entry_component, posted_sum,
		delta_sum, calls, clamped_calls, invalid_count, overflow_count, full_count,
		last, input ready);
	modport sink (input valid, kind, entry_key, entry_component, posted_sum,
		delta_sum, calls, clamped_calls, invalid_count, overflow_count, full_count,
		last, output ready);
endinterface

interface kst_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kst_ctrl.sv =====
// ----------------------------------------------------------------------------
// kst_ctrl
// sequencer for capture, drain, stats and table clearing
// ----------------------------------------------------------------------------
`default_nettype none
module kst_ctrl import kst_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISP, S_DCHK, S_PRD, S_PCHK, S_ZERO, S_ARD,
		S_ADD1, S_ADD2, S_DR_LIST, S_DR_SUM, S_DR_EMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				priority if (!sts.enabled) begin
					state_d = S_IDLE;
				end else if (sts.is_drain && sts.drain_more) begin
					cmd.dr_list_rd = 1'b1;
					state_d = S_DR_LIST;
				end else if (sts.is_drain) begin
					if (!sts.out_busy) begin
						cmd.emit_stats = 1'b1;
						state_d = S_CLEAR;
					end
				end else if (sts.invalid) begin
					cmd.cnt_calls   = 1'b1;
					cmd.cnt_invalid = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.cnt_calls  = 1'b1;
					cmd.calc_delta = 1'b1;
					state_d = S_DCHK;
				end
			end
			S_DCHK: begin
				if (sts.delta_ovf) begin
					cmd.cnt_overflow = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.probe_init = 1'b1;
					state_d = S_PRD;
				end
			end
			S_PRD: begin
				cmd.probe_rd = 1'b1;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				priority if (!sts.slot_valid && sts.slots_exhausted) begin
					cmd.cnt_full = 1'b1;
					state_d = S_IDLE;
				end else if (!sts.slot_valid) begin
					cmd.claim = 1'b1;
					state_d = S_ZERO;
				end else if (sts.key_match) begin
					state_d = S_ARD;
				end else if (sts.tries_last) begin
					cmd.cnt_full = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = S_PRD;
				end
			end
			S_ZERO: begin
				cmd.zero_wr = 1'b1;
				if (sts.zc_last) state_d = S_ARD;
			end
			S_ARD: begin
				cmd.add_rd = 1'b1;
				state_d = S_ADD1;
			end
			S_ADD1: begin
				if (sts.posted_ovf) begin
					cmd.cnt_overflow = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.add_posted = 1'b1;
					state_d = S_ADD2;
				end
			end
			S_ADD2: begin
				if (sts.delta_add_ovf) cmd.cnt_overflow = 1'b1;
				else cmd.add_delta = 1'b1;
				state_d = S_IDLE;
			end
			S_DR_LIST: begin
				cmd.dr_slot_rd = 1'b1;
				state_d = S_DR_SUM;
			end
			S_DR_SUM: begin
				cmd.dr_sum_rd = 1'b1;
				state_d = S_DR_EMIT;
			end
			S_DR_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit_entry = 1'b1;
					state_d = sts.zc_last ? S_IDLE : S_DR_SUM;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/kst_dp.sv =====
// ----------------------------------------------------------------------------
// kst_dp
// slot, sum, count and order memories, counters and the result register
// ----------------------------------------------------------------------------
`default_nettype none
module kst_dp import kst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_req_type,
	input  wire logic [31:0]        in_key,
	input  wire logic signed [7:0]  in_component,
	input  wire logic signed [63:0] in_amount,
	input  wire logic signed [63:0] in_before,
	input  wire logic signed [63:0] in_after,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_data,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_kind,
	output logic [31:0]             out_entry_key,
	output logic [4:0]              out_entry_component,
	output logic signed [63:0]      out_posted_sum,
	output logic signed [63:0]      out_delta_sum,
	output logic [31:0]             out_calls,
	output logic [31:0]             out_clamped_calls,
	output logic [31:0]             out_invalid_count,
	output logic [31:0]             out_overflow_count,
	output logic [31:0]             out_full_count,
	output logic                    out_last
);

	logic              enabled_q;
	logic              req_q;
	logic [31:0]       key_q;
	logic [7:0]        comp_q;
	logic [63:0]       amount_q, before_q, after_q, delta_q;
	logic [SLOT_W-1:0] idx_q, tries_q, clr_q;
	logic [COMP_W-1:0] zc_q;
	logic [CNT_W-1:0]  used_total_q, drain_ptr_q;
	logic [31:0]       st_calls_q, st_inv_q, st_ovf_q, st_full_q;

	// memories
	logic [32:0]       slot_mem [SLOTS];
	logic [63:0]       cnt_mem  [SLOTS];
	logic [SLOT_W-1:0] list_mem [SLOTS];
	logic [63:0]       posted_mem [SUM_DEPTH];
	logic [63:0]       delta_mem  [SUM_DEPTH];
	logic [32:0]       slot_rd_q;
	logic [63:0]       cnt_rd_q, posted_rd_q, delta_rd_q;
	logic [SLOT_W-1:0] list_rd_q;

	logic [SUM_AW-1:0] addr_comp, addr_zc;
	logic [63:0]       posted_new, delta_new;

	assign addr_comp = SUM_AW'(idx_q) * SUM_AW'(COMPONENTS) + SUM_AW'(comp_q[COMP_W-1:0]);
	assign addr_zc   = SUM_AW'(idx_q) * SUM_AW'(COMPONENTS) + SUM_AW'(zc_q);
	assign posted_new = posted_rd_q + amount_q;
	assign delta_new  = delta_rd_q + delta_q;

	always_comb begin
		sts.enabled         = enabled_q;
		sts.is_drain        = (req_q == REQ_DRAIN);
		sts.invalid         = (key_q == 32'd0) || comp_q[7] || (comp_q >= 8'(COMPONENTS));
		sts.delta_ovf       = ((after_q ^ before_q) & (after_q ^ delta_q)) >> 63 != 64'd0;
		sts.slot_valid      = slot_rd_q[32];
		sts.key_match       = (slot_rd_q[31:0] == key_q);
		sts.slots_exhausted = (used_total_q >= CNT_W'(SLOTS));
		sts.tries_last      = (tries_q == SLOT_W'(SLOTS - 1));
		sts.zc_last         = (zc_q == COMP_W'(COMPONENTS - 1));
		sts.posted_ovf      = ((posted_rd_q ^ posted_new) & (amount_q ^ posted_new)) >> 63
			!= 64'd0;
		sts.delta_add_ovf   = ((delta_rd_q ^ delta_new) & (delta_q ^ delta_new)) >> 63
			!= 64'd0;
		sts.drain_more      = (drain_ptr_q < used_total_q);
		sts.out_busy        = out_valid && !out_ready;
		sts.clr_last        = (clr_q == SLOT_W'(SLOTS - 1));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			used_total_q <= '0;
			drain_ptr_q  <= '0;
			st_calls_q   <= '0;
			st_inv_q     <= '0;
			st_ovf_q     <= '0;
			st_full_q    <= '0;
			clr_q        <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_valid) enabled_q <= cfg_data;
			if (cmd.cnt_calls) st_calls_q <= st_calls_q + 32'd1;
			if (cmd.cnt_invalid) st_inv_q <= st_inv_q + 32'd1;
			if (cmd.cnt_overflow) st_ovf_q <= st_ovf_q + 32'd1;
			if (cmd.cnt_full) st_full_q <= st_full_q + 32'd1;
			if (cmd.claim) used_total_q <= used_total_q + CNT_W'(1);
			if (cmd.clr_step) clr_q <= clr_q + SLOT_W'(1);
			if (cmd.emit_entry && sts.zc_last) drain_ptr_q <= drain_ptr_q + CNT_W'(1);
			if (cmd.emit_stats) begin
				st_calls_q   <= '0;
				st_inv_q     <= '0;
				st_ovf_q     <= '0;
				st_full_q    <= '0;
				used_total_q <= '0;
				drain_ptr_q  <= '0;
				clr_q        <= '0;
			end
			if (cmd.emit_entry || cmd.emit_stats) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			req_q    <= in_req_type;
			key_q    <= in_key;
			comp_q   <= in_component;
			amount_q <= in_amount;
			before_q <= in_before;
			after_q  <= in_after;
		end
		if (cmd.calc_delta) delta_q <= after_q - before_q;
		if (cmd.probe_init) begin
			idx_q   <= key_q[HASH_LSB +: SLOT_W];
			tries_q <= '0;
		end
		if (cmd.probe_next) begin
			idx_q   <= idx_q + SLOT_W'(1);
			tries_q <= tries_q + SLOT_W'(1);
		end
		if (cmd.dr_slot_rd) idx_q <= list_rd_q;
		if (cmd.claim || cmd.dr_slot_rd) zc_q <= '0;
		else if (cmd.zero_wr || cmd.emit_entry) zc_q <= zc_q + COMP_W'(1);
		if (cmd.emit_entry) begin
			out_kind            <= KIND_ENTRY;
			out_entry_key       <= slot_rd_q[31:0];
			out_entry_component <= 5'(zc_q);
			out_posted_sum      <= posted_rd_q;
			out_delta_sum       <= delta_rd_q;
			out_calls           <= cnt_rd_q[31:0];
			out_clamped_calls   <= cnt_rd_q[63:32];
			out_invalid_count   <= '0;
			out_overflow_count  <= '0;
			out_full_count      <= '0;
			out_last            <= sts.zc_last;
		end else if (cmd.emit_stats) begin
			out_kind            <= KIND_STATS;
			out_entry_key       <= '0;
			out_entry_component <= '0;
			out_posted_sum      <= '0;
			out_delta_sum       <= '0;
			out_calls           <= st_calls_q;
			out_clamped_calls   <= '0;
			out_invalid_count   <= st_inv_q;
			out_overflow_count  <= st_ovf_q;
			out_full_count      <= st_full_q;
			out_last            <= 1'b1;
		end
	end

	// slot memory: valid mark and key
	always_ff @(posedge clk) begin
		if (cmd.clr_step) slot_mem[clr_q] <= '0;
		else if (cmd.claim) slot_mem[idx_q] <= {1'b1, key_q};
		if (cmd.probe_rd) slot_rd_q <= slot_mem[idx_q];
		else if (cmd.dr_slot_rd) slot_rd_q <= slot_mem[list_rd_q];
	end

	// per-entry call and clamped counts
	always_ff @(posedge clk) begin
		if (cmd.claim) cnt_mem[idx_q] <= '0;
		else if (cmd.add_delta)
			cnt_mem[idx_q] <= {cnt_rd_q[63:32] + 32'(amount_q != delta_q),
				cnt_rd_q[31:0] + 32'd1};
		if (cmd.add_rd) cnt_rd_q <= cnt_mem[idx_q];
		else if (cmd.dr_slot_rd) cnt_rd_q <= cnt_mem[list_rd_q];
	end

	// insertion order list
	always_ff @(posedge clk) begin
		if (cmd.claim) list_mem[used_total_q[SLOT_W-1:0]] <= idx_q;
		if (cmd.dr_list_rd) list_rd_q <= list_mem[drain_ptr_q[SLOT_W-1:0]];
	end

	// posted sums
	always_ff @(posedge clk) begin
		if (cmd.zero_wr) posted_mem[addr_zc] <= '0;
		else if (cmd.add_posted) posted_mem[addr_comp] <= posted_new;
		if (cmd.add_rd) posted_rd_q <= posted_mem[addr_comp];
		else if (cmd.dr_sum_rd) posted_rd_q <= posted_mem[addr_zc];
	end

	// delta sums
	always_ff @(posedge clk) begin
		if (cmd.zero_wr) delta_mem[addr_zc] <= '0;
		else if (cmd.add_delta) delta_mem[addr_comp] <= delta_new;
		if (cmd.add_rd) delta_rd_q <= delta_mem[addr_comp];
		else if (cmd.dr_sum_rd) delta_rd_q <= delta_mem[addr_zc];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/keyed_sum_aggregation_table.sv =====
// ----------------------------------------------------------------------------
// keyed_sum_aggregation_table
// linear-probing hash aggregation of per-component signed sums with drain
// ----------------------------------------------------------------------------
// capture: a null key or bad component is counted as invalid, a delta overflow is counted,
//   otherwise the key is probed and a newly claimed slot has its COMPONENTS sums zeroed
// drain: entry by entry, one sum read per result transfer
// stats drain: the stats result, then a clearing pass over the SLOTS entries of the slot memory
// after reset the same clearing pass runs before the first item
// one item at a time; a waiting result transfer stalls only the next result
`default_nettype none
module keyed_sum_aggregation_table import kst_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	kst_item_if.sink     item,
	kst_result_if.source result,
	kst_cfg_if.sink      cfg
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// the user is to make config writes only while idle, unenforced by the block; they are always taken
	assign cfg.ready  = 1'b1;
	assign item.ready = in_ready;

	// sequencer
	kst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// memories, counters and result register
	kst_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_req_type         (item.req_type),
		.in_key              (item.key),
		.in_component        (item.component),
		.in_amount           (item.amount),
		.in_before           (item.before_value),
		.in_after            (item.after_value),
		.cfg_valid           (cfg.valid),
		.cfg_data            (cfg.data),
		.cmd                 (cmd),
		.sts                 (sts),
		.out_valid           (result.valid),
		.out_ready           (result.ready),
		.out_kind            (result.kind),
		.out_entry_key       (result.entry_key),
		.out_entry_component (result.entry_component),
		.out_posted_sum      (result.posted_sum),
		.out_delta_sum       (result.delta_sum),
		.out_calls           (result.calls),
		.out_clamped_calls   (result.clamped_calls),
		.out_invalid_count   (result.invalid_count),
		.out_overflow_count  (result.overflow_count),
		.out_full_count      (result.full_count),
		.out_last            (result.last)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/kst_checker.sv =====
// ----------------------------------------------------------------------------
// kst_checker
// port-level checks of the aggregation table
// ----------------------------------------------------------------------------
`default_nettype none
module kst_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_kind,
	input wire logic out_last,
	input wire logic [31:0] out_invalid_count,
	input wire logic [31:0] out_overflow_count,
	input wire logic [31:0] out_full_count
);

	// a result waiting for transfer stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one item at a time: no item taken right after another
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// a stats result always closes its drain
	a_stats_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> out_last)
		else $error("stats result without last");

	// entry results carry no stats counters
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> out_invalid_count == 32'd0 &&
		out_overflow_count == 32'd0 && out_full_count == 32'd0)
		else $error("entry result with stats fields");

endmodule

bind keyed_sum_aggregation_table kst_checker u_kst_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (item.valid),
	.in_ready           (item.ready),
	.out_valid          (result.valid),
	.out_ready          (result.ready),
	.out_kind           (result.kind),
	.out_last           (result.last),
	.out_invalid_count  (result.invalid_count),
	.out_overflow_count (result.overflow_count),
	.out_full_count     (result.full_count)
);
`default_nettype wire
